// ===== rtl/core/iamc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm mode controller package
// Shared types, codes and reset constants for the alarm mode controller.
// ----------------------------------------------------------------------------
package iamc_pkg;

  // Default widths of sensor vectors and countdown timer.
  localparam int SensorBitsDef = 8;
  localparam int TimerBitsDef  = 16;

  // Reset values of the delay registers, in poll ticks.
  localparam int EntryDelayReset = 30 * 1000;
  localparam int ExitDelayReset  = 10 * 1000;

  // Result transactions are padded up to whole bytes.
  localparam int OutDataW = 16;

  // Operation carried with each input transaction.
  typedef enum logic [1:0] {
    OP_POLL   = 2'd0,
    OP_PIN    = 2'd1,
    OP_ARM    = 2'd2,
    OP_DISARM = 2'd3
  } op_e;

  // Panel modes.
  typedef enum logic [2:0] {
    MODE_DAY        = 3'd0,
    MODE_WAIT_OPEN  = 3'd1,
    MODE_WAIT_CLOSE = 3'd2,
    MODE_PRE_ARM    = 3'd3,
    MODE_ARMED      = 3'd4,
    MODE_ENTRY      = 3'd5
  } mode_e;

  // Arm state change notices.
  typedef enum logic [1:0] {
    NOTICE_NONE     = 2'd0,
    NOTICE_ARMED    = 2'd1,
    NOTICE_DISARMED = 2'd2
  } notice_e;

  // Sounder commands.
  typedef enum logic [1:0] {
    TUNE_NONE    = 2'd0,
    TUNE_WARNING = 2'd1,
    TUNE_ARMING  = 2'd2,
    TUNE_STOP    = 2'd3
  } tune_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_EXIT_MASK   = 2'd0,
    CFG_ENTRY_DELAY = 2'd1,
    CFG_EXIT_DELAY  = 2'd2
  } cfg_idx_e;

  // One result, mode in the lowest bits.
  typedef struct packed {
    tune_e   tune;
    notice_e notice;
    logic    motion;
    logic    triggered;
    logic    strobe;
    mode_e   mode;
  } result_t;

  localparam int ResultW = $bits(result_t);

endpackage
`default_nettype wire

// ===== rtl/core/intruder_alarm_mode_controller_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Intruder alarm mode controller
// Mode controller of an alarm panel: exit sequence, armed watch, entry
// countdown and alarm trigger.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on the s_axis channel: the operation (poll tick,
//   PIN, arm, disarm) in tuser, the sensor, tamper and live sensor vectors in
//   tdata. Every input transaction gives exactly one result transaction on
//   the m_axis channel carrying mode, strobe level, trigger pulse, motion
//   pulse, arm notice and sounder command.
//   Configuration writes use the cfg channel (index 0 exit door mask, 1 entry
//   delay, 2 exit delay), which is always ready; write only while idle.
//   A transaction accepted into the input register has its result loaded into
//   the output register, from which it is presented on the m_axis channel.
//   Throughput: one transaction per cycle while the receiver keeps taking
//   results; the mode update is a single pass of logic between the input
//   and output registers.
//   When the receiver stalls, the output register holds its result and the
//   input register still takes one more transaction before tready drops.
//   Reset puts the panel in day mode with the strobe off, the countdown at
//   zero and the registers at mask 1, entry delay 30000, exit delay 10000.
// ----------------------------------------------------------------------------
module intruder_alarm_mode_controller_unit
  import iamc_pkg::*;
#(
  parameter int SENSOR_BITS = SensorBitsDef,
  parameter int TIMER_BITS  = TimerBitsDef,
  localparam int InDataW    = ((3 * SENSOR_BITS + 7) / 8) * 8,
  localparam int CfgW       = (SENSOR_BITS > TIMER_BITS) ? SENSOR_BITS : TIMER_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input stream.
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata: sensor_events, tamper_events, live_sensors (lowest first), zero pad
  input  wire logic [InDataW-1:0] s_axis_tdata,
  // tuser: operation
  input  wire logic [1:0]         s_axis_tuser,
  // Result stream.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // tdata: mode[2:0], strobe_res, triggered, motion, armed_notice[1:0],
  //        tune_command[1:0], zero pad
  output logic [OutDataW-1:0]     m_axis_tdata,
  // Configuration writes.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  localparam int ItemW = 2 + 3 * SENSOR_BITS;

  logic [ItemW-1:0]       item_in;
  logic [ItemW-1:0]       item_q;
  logic                   item_valid;
  logic                   res_ready;
  logic                   fire;
  result_t                result;
  logic [ResultW-1:0]     result_q;
  logic [SENSOR_BITS-1:0] exit_mask;
  logic [TIMER_BITS-1:0]  entry_delay;
  logic [TIMER_BITS-1:0]  exit_delay;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  iamc_cfg_regs #(
    .SensorBits (SENSOR_BITS),
    .TimerBits  (TIMER_BITS),
    .CfgW       (CfgW)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (cfg_valid_i),
    .wr_index_i    (cfg_index_i),
    .wr_data_i     (cfg_data_i),
    .exit_mask_o   (exit_mask),
    .entry_delay_o (entry_delay),
    .exit_delay_o  (exit_delay)
  );

  // Input register: operation in the low bits, then the three vectors.
  assign item_in = {s_axis_tdata[3*SENSOR_BITS-1:0], s_axis_tuser};

  iamc_pipe_reg #(
    .Width (ItemW)
  ) u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (item_in),
    .out_valid_o (item_valid),
    .out_ready_i (res_ready),
    .out_data_o  (item_q)
  );

  // A transaction is processed when it moves into the output register.
  assign fire = item_valid && res_ready;

  iamc_mode_core #(
    .SensorBits (SENSOR_BITS),
    .TimerBits  (TIMER_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .op_i          (item_q[1:0]),
    .sensor_i      (item_q[2+:SENSOR_BITS]),
    .tamper_i      (item_q[2+SENSOR_BITS+:SENSOR_BITS]),
    .live_i        (item_q[2+2*SENSOR_BITS+:SENSOR_BITS]),
    .exit_mask_i   (exit_mask),
    .entry_delay_i (entry_delay),
    .exit_delay_i  (exit_delay),
    .result_o      (result)
  );

  // Output register.
  iamc_pipe_reg #(
    .Width (ResultW)
  ) u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (result_q)
  );

  assign m_axis_tdata = {{(OutDataW - ResultW){1'b0}}, result_q};

endmodule
`default_nettype wire

// ===== rtl/core/iamc_pipe_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm mode controller pipeline register
// One valid/ready register stage that accepts a new transaction every cycle
// while the downstream side keeps taking them.
// ----------------------------------------------------------------------------
module iamc_pipe_reg #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [Width-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [Width-1:0]      out_data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // The stage can load when empty or when its content leaves this cycle.
  assign in_ready_o = !valid_q || out_ready_i;

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/core/iamc_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm mode controller configuration registers
// Holds the exit door mask and the entry and exit delays.
// ----------------------------------------------------------------------------
module iamc_cfg_regs
  import iamc_pkg::*;
#(
  parameter int SensorBits = SensorBitsDef,
  parameter int TimerBits  = TimerBitsDef,
  parameter int CfgW       = TimerBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_en_i,
  input  wire logic [1:0]            wr_index_i,
  input  wire logic [CfgW-1:0]       wr_data_i,
  output logic [SensorBits-1:0]      exit_mask_o,
  output logic [TimerBits-1:0]       entry_delay_o,
  output logic [TimerBits-1:0]       exit_delay_o
);

  logic [SensorBits-1:0] exit_mask_q;
  logic [TimerBits-1:0]  entry_delay_q;
  logic [TimerBits-1:0]  exit_delay_q;

  // Register writes; an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exit_mask_q   <= SensorBits'(1);
      entry_delay_q <= TimerBits'(EntryDelayReset);
      exit_delay_q  <= TimerBits'(ExitDelayReset);
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_EXIT_MASK:   exit_mask_q   <= wr_data_i[SensorBits-1:0];
        CFG_ENTRY_DELAY: entry_delay_q <= wr_data_i[TimerBits-1:0];
        CFG_EXIT_DELAY:  exit_delay_q  <= wr_data_i[TimerBits-1:0];
        default: ;
      endcase
    end
  end

  assign exit_mask_o   = exit_mask_q;
  assign entry_delay_o = entry_delay_q;
  assign exit_delay_o  = exit_delay_q;

endmodule
`default_nettype wire

// ===== rtl/core/iamc_mode_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm mode controller core
// Mode state machine, countdown and strobe; computes one result per
// transaction and commits the new state when that result is stored.
// ----------------------------------------------------------------------------
module iamc_mode_core
  import iamc_pkg::*;
#(
  parameter int SensorBits = SensorBitsDef,
  parameter int TimerBits  = TimerBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire logic [1:0]            op_i,
  input  wire logic [SensorBits-1:0] sensor_i,
  input  wire logic [SensorBits-1:0] tamper_i,
  input  wire logic [SensorBits-1:0] live_i,
  input  wire logic [SensorBits-1:0] exit_mask_i,
  input  wire logic [TimerBits-1:0]  entry_delay_i,
  input  wire logic [TimerBits-1:0]  exit_delay_i,
  output result_t                    result_o
);

  mode_e                mode_q, mode_d;
  logic [TimerBits-1:0] count_q, count_d;
  logic                 strobe_q, strobe_d;
  logic [TimerBits-1:0] count_dec;
  logic                 count_zero;
  logic                 any_event;
  logic                 entry_event;
  logic                 door_open;

  // Countdown step that holds at zero.
  assign count_dec   = (count_q != '0) ? count_q - TimerBits'(1) : count_q;
  assign count_zero  = (count_dec == '0);
  assign any_event   = (sensor_i != '0) || (tamper_i != '0);
  assign entry_event = ((sensor_i & exit_mask_i) != '0) && (tamper_i == '0);
  assign door_open   = ((live_i & exit_mask_i) != '0);

  // Next state and result.
  always_comb begin
    mode_d             = mode_q;
    count_d            = count_q;
    strobe_d           = strobe_q;
    result_o.triggered = 1'b0;
    result_o.motion    = 1'b0;
    result_o.notice    = NOTICE_NONE;
    result_o.tune      = TUNE_NONE;
    case (op_e'(op_i))
      OP_POLL: begin
        result_o.motion = any_event;
        case (mode_q)
          MODE_ARMED: begin
            if (any_event) begin
              if (entry_event) begin
                mode_d        = MODE_ENTRY;
                count_d       = entry_delay_i;
                result_o.tune = TUNE_WARNING;
              end else begin
                strobe_d           = 1'b1;
                result_o.triggered = 1'b1;
              end
            end
          end
          MODE_ENTRY: begin
            count_d = count_dec;
            if (count_zero) begin
              strobe_d           = 1'b1;
              result_o.triggered = 1'b1;
            end
          end
          MODE_WAIT_OPEN: begin
            if (door_open) begin
              mode_d = MODE_WAIT_CLOSE;
            end
          end
          MODE_WAIT_CLOSE: begin
            if (!door_open) begin
              mode_d        = MODE_PRE_ARM;
              count_d       = exit_delay_i;
              result_o.tune = TUNE_ARMING;
            end
          end
          MODE_PRE_ARM: begin
            count_d = count_dec;
            if (count_zero) begin
              mode_d          = MODE_ARMED;
              result_o.tune   = TUNE_STOP;
              result_o.notice = NOTICE_ARMED;
            end
          end
          default: ;
        endcase
      end
      OP_PIN: begin
        if (mode_q != MODE_DAY) begin
          strobe_d        = 1'b0;
          mode_d          = MODE_DAY;
          result_o.tune   = TUNE_STOP;
          result_o.notice = NOTICE_DISARMED;
        end else begin
          mode_d        = MODE_WAIT_OPEN;
          result_o.tune = TUNE_WARNING;
        end
      end
      OP_ARM: begin
        mode_d          = MODE_ARMED;
        result_o.notice = NOTICE_ARMED;
      end
      default: begin
        strobe_d        = 1'b0;
        mode_d          = MODE_DAY;
        result_o.notice = NOTICE_DISARMED;
      end
    endcase
    result_o.mode   = mode_d;
    result_o.strobe = strobe_d;
  end

  // State commits when the result moves into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DAY;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

endmodule
`default_nettype wire
